@@ hw/rtl/qt_pkg.sv @@
`timescale 1ns / 1ps
package qt_pkg;

  localparam int USER_ENTRIES_DEF    = 128;
  localparam int PROCESS_ENTRIES_DEF = 512;
  localparam int TYPE_COUNT_DEF      = 2;

  localparam int CNT_W = 8;
  localparam int ID_W  = 32;

  localparam logic [CNT_W-1:0] USER_LIMIT_RST    = 8'd128;
  localparam logic [CNT_W-1:0] PROCESS_LIMIT_RST = 8'd64;

  typedef enum logic {
    REG_USER_LIMIT    = 1'b0,
    REG_PROCESS_LIMIT = 1'b1
  } reg_index_t;

  typedef enum logic {
    OP_CHARGE  = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_USER_LIMIT = 2'd1,
    ST_PROC_LIMIT = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_U_SCAN,
    S_U_RD,
    S_U_MOD,
    S_P_SCAN,
    S_P_RD,
    S_P_MOD,
    S_FIN
  } state_t;

endpackage

@@ hw/rtl/qt_ram.sv @@
`timescale 1ns / 1ps
module qt_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/two_level_quota_tracker_top.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Beat contents
// in      | in        | in_valid/in_stall  | operation, user_id, process_id, limit_type
// out     | out       | out_valid/out_stall| status
// cfg     | in        | cfg_write          | cfg_index, cfg_data
//
// One request is handled at a time. Each table is searched linearly over its
// allocated entries, one key memory read per cycle, and the next request is
// taken once the result has been passed to the output register. Entries fill
// from slot zero upward and are never freed, so a fill count stands in for the
// valid bits; reset clears the counts at once and needs no clearing pass.
// A finished result waits in the output register; a stalled output only holds
// the next request at its end.
module two_level_quota_tracker_top #(
  parameter int USER_ENTRIES    = qt_pkg::USER_ENTRIES_DEF,
  parameter int PROCESS_ENTRIES = qt_pkg::PROCESS_ENTRIES_DEF,
  parameter int TYPE_COUNT      = qt_pkg::TYPE_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    operation,
  input  logic [qt_pkg::ID_W-1:0] user_id,
  input  logic [qt_pkg::ID_W-1:0] process_id,
  input  logic                    limit_type,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              status,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [qt_pkg::CNT_W-1:0] cfg_data
);
  import qt_pkg::*;

  localparam int UAW  = $clog2(USER_ENTRIES);
  localparam int UCW  = $clog2(USER_ENTRIES + 1);
  localparam int PAW  = $clog2(PROCESS_ENTRIES);
  localparam int PCW  = $clog2(PROCESS_ENTRIES + 1);
  localparam int TW   = $clog2(TYPE_COUNT);
  localparam int ROWW = CNT_W * TYPE_COUNT;
  localparam logic [UCW-1:0] U_MAX = UCW'(USER_ENTRIES);
  localparam logic [PCW-1:0] P_MAX = PCW'(PROCESS_ENTRIES);

  state_t state, state_next;

  logic             op_r;
  logic [ID_W-1:0]  uid_r, pid_r;
  logic [TW-1:0]    t_r;
  logic [CNT_W-1:0] ulim, plim;
  logic [UCW-1:0]   ufill, uidx;
  logic [PCW-1:0]   pfill, pidx;
  logic             upend, ppend;
  logic [UAW-1:0]   upos, uslot;
  logic [PAW-1:0]   ppos, pslot;
  logic [ROWW-1:0]  urow;
  status_t          sq;

  logic [ID_W-1:0]  uk_rd, pk_rd;
  logic [ROWW-1:0]  uc_rd, pc_rd;

  logic            uk_we, pk_we, uc_we, pc_we;
  logic [UAW-1:0]  uc_waddr;
  logic [ROWW-1:0] uc_wdata, pc_wdata;
  logic [PAW-1:0]  pc_waddr;

  logic             accept, out_free;
  logic             u_hit, u_miss, p_hit, p_miss;
  logic [CNT_W-1:0] uc, pc;
  logic [ROWW-1:0]  u_inc, u_dec, p_inc, p_dec, new_row;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign u_hit  = upend && (uk_rd == uid_r);
  assign u_miss = !u_hit && (uidx == ufill);
  assign p_hit  = ppend && (pk_rd == pid_r);
  assign p_miss = !p_hit && (pidx == pfill);

  assign uc = uc_rd[t_r*CNT_W +: CNT_W];
  assign pc = pc_rd[t_r*CNT_W +: CNT_W];

  always_comb begin
    u_inc   = uc_rd;
    u_dec   = uc_rd;
    p_inc   = pc_rd;
    p_dec   = pc_rd;
    new_row = '0;
    u_inc[t_r*CNT_W +: CNT_W]   = uc + 1'b1;
    u_dec[t_r*CNT_W +: CNT_W]   = (uc == '0) ? uc : uc - 1'b1;
    p_inc[t_r*CNT_W +: CNT_W]   = pc + 1'b1;
    p_dec[t_r*CNT_W +: CNT_W]   = (pc == '0) ? pc : pc - 1'b1;
    new_row[t_r*CNT_W +: CNT_W] = CNT_W'(1);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_U_SCAN;
      S_U_SCAN: begin
        if (u_hit) begin
          state_next = S_U_RD;
        end else if (u_miss) begin
          if (op_r == OP_CHARGE && ufill == U_MAX) state_next = S_FIN;
          else state_next = S_P_SCAN;
        end
      end
      S_U_RD:   state_next = S_U_MOD;
      S_U_MOD: begin
        if (op_r == OP_CHARGE && uc >= ulim) state_next = S_FIN;
        else state_next = S_P_SCAN;
      end
      S_P_SCAN: begin
        if (p_hit) state_next = S_P_RD;
        else if (p_miss) state_next = S_FIN;
      end
      S_P_RD:   state_next = S_P_MOD;
      S_P_MOD:  state_next = S_FIN;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Memory write controls. A process refusal writes the saved user row back.
  always_comb begin
    uk_we    = 1'b0;
    pk_we    = 1'b0;
    uc_we    = 1'b0;
    pc_we    = 1'b0;
    uc_waddr = uslot;
    uc_wdata = urow;
    pc_waddr = pslot;
    pc_wdata = p_inc;
    unique case (state)
      S_U_SCAN: begin
        if (u_miss && op_r == OP_CHARGE && ufill != U_MAX) begin
          uk_we    = 1'b1;
          uc_we    = 1'b1;
          uc_waddr = ufill[UAW-1:0];
          uc_wdata = new_row;
        end
      end
      S_U_MOD: begin
        if (op_r == OP_RELEASE) begin
          uc_we    = 1'b1;
          uc_wdata = u_dec;
        end else if (uc < ulim) begin
          uc_we    = 1'b1;
          uc_wdata = u_inc;
        end
      end
      S_P_SCAN: begin
        if (p_miss && op_r == OP_CHARGE) begin
          if (pfill == P_MAX) begin
            uc_we = 1'b1;
          end else begin
            pk_we    = 1'b1;
            pc_we    = 1'b1;
            pc_waddr = pfill[PAW-1:0];
            pc_wdata = new_row;
          end
        end
      end
      S_P_MOD: begin
        if (op_r == OP_RELEASE) begin
          pc_we    = 1'b1;
          pc_wdata = p_dec;
        end else if (pc < plim) begin
          pc_we    = 1'b1;
        end else begin
          uc_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ulim      <= USER_LIMIT_RST;
      plim      <= PROCESS_LIMIT_RST;
      ufill     <= '0;
      pfill     <= '0;
      upend     <= 1'b0;
      ppend     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        if (cfg_index == REG_USER_LIMIT) ulim <= cfg_data;
        else plim <= cfg_data;
      end
      if (state == S_FIN && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            uidx  <= '0;
            pidx  <= '0;
            upend <= 1'b0;
            ppend <= 1'b0;
            sq    <= ST_OK;
            op_r  <= operation;
            uid_r <= user_id;
            pid_r <= process_id;
            t_r   <= TW'(limit_type);
          end
        end
        S_U_SCAN: begin
          if (u_hit) begin
            uslot <= upos;
          end else if (u_miss) begin
            upend <= 1'b0;
            if (op_r == OP_CHARGE) begin
              if (ufill == U_MAX) begin
                sq <= ST_FULL;
              end else begin
                uslot <= ufill[UAW-1:0];
                urow  <= '0;
                ufill <= ufill + 1'b1;
              end
            end
          end else begin
            upend <= 1'b1;
            upos  <= uidx[UAW-1:0];
            uidx  <= uidx + 1'b1;
          end
        end
        S_U_MOD: begin
          urow <= uc_rd;
          if (op_r == OP_CHARGE && uc >= ulim) sq <= ST_USER_LIMIT;
        end
        S_P_SCAN: begin
          if (p_hit) begin
            pslot <= ppos;
          end else if (p_miss) begin
            if (op_r == OP_CHARGE) begin
              if (pfill == P_MAX) sq <= ST_FULL;
              else pfill <= pfill + 1'b1;
            end
          end else begin
            ppend <= 1'b1;
            ppos  <= pidx[PAW-1:0];
            pidx  <= pidx + 1'b1;
          end
        end
        S_P_MOD: begin
          if (op_r == OP_CHARGE && pc >= plim) sq <= ST_PROC_LIMIT;
        end
        S_FIN: begin
          if (out_free) status <= sq;
        end
        default: ;
      endcase
    end
  end

  qt_ram #(.W(ID_W), .D(USER_ENTRIES)) u_keys (
    .clk(clk), .we(uk_we), .waddr(ufill[UAW-1:0]), .wdata(uid_r),
    .raddr(uidx[UAW-1:0]), .rdata(uk_rd)
  );
  qt_ram #(.W(ROWW), .D(USER_ENTRIES)) u_counts (
    .clk(clk), .we(uc_we), .waddr(uc_waddr), .wdata(uc_wdata),
    .raddr(uslot), .rdata(uc_rd)
  );
  qt_ram #(.W(ID_W), .D(PROCESS_ENTRIES)) p_keys (
    .clk(clk), .we(pk_we), .waddr(pfill[PAW-1:0]), .wdata(pid_r),
    .raddr(pidx[PAW-1:0]), .rdata(pk_rd)
  );
  qt_ram #(.W(ROWW), .D(PROCESS_ENTRIES)) p_counts (
    .clk(clk), .we(pc_we), .waddr(pc_waddr), .wdata(pc_wdata),
    .raddr(pslot), .rdata(pc_rd)
  );

  a_ufill_bound: assert property (@(posedge clk) disable iff (rst) ufill <= U_MAX)
    else $error("user fill count beyond table size");
  a_pfill_bound: assert property (@(posedge clk) disable iff (rst) pfill <= P_MAX)
    else $error("process fill count beyond table size");
  a_fin_delivers: assert property (@(posedge clk) disable iff (rst)
      (state == S_FIN && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished request not delivered");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
      accept |=> (state == S_U_SCAN))
    else $error("accepted request did not start the user search");
  a_no_double_write: assert property (@(posedge clk) disable iff (rst)
      !(uk_we && pk_we))
    else $error("both key tables written in one cycle");
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import qt_pkg::*;

  typedef logic [1:0][CNT_W-1:0] cnt_pair_t;
  typedef struct {
    op_t              op;
    logic [ID_W-1:0]  uid;
    logic [ID_W-1:0]  pid;
    logic             kind;
  } request_t;

  localparam int USER_SLOTS = USER_ENTRIES_DEF;
  localparam int PROC_SLOTS = PROCESS_ENTRIES_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = 1'b0;
  logic [ID_W-1:0] user_id = '0;
  logic [ID_W-1:0] process_id = '0;
  logic limit_type = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;

  two_level_quota_tracker_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .user_id(user_id), .process_id(process_id),
    .limit_type(limit_type),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Quota model state: entries are never freed, so a table is just a map.
  cnt_pair_t user_quota[logic [ID_W-1:0]];
  cnt_pair_t proc_quota[logic [ID_W-1:0]];
  logic [CNT_W-1:0] user_cap = USER_LIMIT_RST;
  logic [CNT_W-1:0] proc_cap = PROCESS_LIMIT_RST;

  request_t  pending_reqs[$];
  status_t   expected_status[$];
  logic [ID_W-1:0] user_pool[$];
  logic [ID_W-1:0] proc_pool[$];
  int mismatches = 0;
  int accepted = 0;

  // 0 charged, 1 refused at limit, 2 table full.
  function automatic int charge_level(ref cnt_pair_t tab[logic [ID_W-1:0]],
                                      input int slots, input logic [ID_W-1:0] key,
                                      input logic kind, input logic [CNT_W-1:0] cap);
    cnt_pair_t fresh;
    if (tab.exists(key)) begin
      if (tab[key][kind] >= cap) return 1;
      tab[key][kind] = tab[key][kind] + 1'b1;
      return 0;
    end
    if (tab.num() >= slots) return 2;
    fresh = '0;
    fresh[kind] = CNT_W'(1);
    tab[key] = fresh;
    return 0;
  endfunction

  function automatic void release_level(ref cnt_pair_t tab[logic [ID_W-1:0]],
                                        input logic [ID_W-1:0] key, input logic kind);
    if (tab.exists(key) && tab[key][kind] != 0)
      tab[key][kind] = tab[key][kind] - 1'b1;
  endfunction

  function automatic status_t quota_status(request_t r);
    int res;
    if (r.op == OP_RELEASE) begin
      release_level(user_quota, r.uid, r.kind);
      release_level(proc_quota, r.pid, r.kind);
      return ST_OK;
    end
    res = charge_level(user_quota, USER_SLOTS, r.uid, r.kind, user_cap);
    if (res == 1) return ST_USER_LIMIT;
    if (res == 2) return ST_FULL;
    res = charge_level(proc_quota, PROC_SLOTS, r.pid, r.kind, proc_cap);
    if (res == 0) return ST_OK;
    release_level(user_quota, r.uid, r.kind);
    return (res == 1) ? ST_PROC_LIMIT : ST_FULL;
  endfunction

  initial begin
    forever #2 clk = ~clk;
  end

  // Request driver: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    request_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        r.op = op_t'(operation);
        r.uid = user_id;
        r.pid = process_id;
        r.kind = limit_type;
        expected_status.push_back(quota_status(r));
        accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          r = pending_reqs.pop_front();
          operation <= r.op;
          user_id <= r.uid;
          process_id <= r.pid;
          limit_type <= r.kind;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output back-pressure: a changing pattern, plus one long hold-off.
  int hold_left = 0;
  bit held_once = 0;
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (!held_once && accepted >= 300) begin
      held_once = 1;
      hold_left = 600;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Result checker.
  always @(posedge clk) begin
    status_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: status %0d", status);
      end else begin
        want = expected_status.pop_front();
        if (status !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("status mismatch: expected %0d, got %0d", want, status);
        end
      end
    end
  end

  task automatic add_req(op_t op, logic [ID_W-1:0] uid, logic [ID_W-1:0] pid,
                         logic kind);
    request_t r;
    r.op = op;
    r.uid = uid;
    r.pid = pid;
    r.kind = kind;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_status.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CNT_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_USER_LIMIT) user_cap = value;
    else proc_cap = value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Well-formed traffic mostly reuses known ids; fresh ids grow the tables.
  task automatic random_phase(int count, int release_pct, int fresh_uid_pct,
                              int fresh_pid_pct);
    logic [ID_W-1:0] uid, pid;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < fresh_uid_pct || user_pool.size() == 0) begin
        uid = $urandom();
        user_pool.push_back(uid);
      end else begin
        uid = user_pool[$urandom_range(0, user_pool.size() > 8 ? 8 : user_pool.size() - 1)];
      end
      if ($urandom_range(0, 99) < fresh_pid_pct || proc_pool.size() == 0) begin
        pid = $urandom();
        proc_pool.push_back(pid);
      end else begin
        pid = proc_pool[$urandom_range(0, proc_pool.size() > 12 ? 12 : proc_pool.size() - 1)];
      end
      add_req(($urandom_range(0, 99) < release_pct) ? OP_RELEASE : OP_CHARGE,
              uid, pid, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed checks with tight limits so both limit refusal paths show up.
    write_reg(REG_USER_LIMIT, 8'd2);
    write_reg(REG_PROCESS_LIMIT, 8'd1);
    add_req(OP_CHARGE, 32'd0, 32'd0, 1'b0);
    add_req(OP_CHARGE, 32'd0, 32'hFFFF_FFFF, 1'b0);
    add_req(OP_CHARGE, 32'd0, 32'd7, 1'b0);
    add_req(OP_CHARGE, 32'hFFFF_FFFF, 32'd0, 1'b0);
    add_req(OP_CHARGE, 32'hFFFF_FFFF, 32'd0, 1'b1);
    add_req(OP_CHARGE, 32'hFFFF_FFFF, 32'd0, 1'b1);
    add_req(OP_RELEASE, 32'd0, 32'd0, 1'b0);
    add_req(OP_RELEASE, 32'd0, 32'd0, 1'b0);
    add_req(OP_RELEASE, 32'd0, 32'd0, 1'b0);
    add_req(OP_RELEASE, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 1'b1);
    add_req(OP_CHARGE, 32'd0, 32'd0, 1'b0);
    add_req(OP_CHARGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    drain();
    // Lower the limit under the counts already held.
    write_reg(REG_USER_LIMIT, 8'd1);
    add_req(OP_CHARGE, 32'd0, 32'd3, 1'b0);
    add_req(OP_CHARGE, 32'hFFFF_FFFF, 32'd4, 1'b1);
    drain();

    write_reg(REG_USER_LIMIT, USER_LIMIT_RST);
    write_reg(REG_PROCESS_LIMIT, PROCESS_LIMIT_RST);
    random_phase(300, 30, 3, 4);
    drain();
    write_reg(REG_USER_LIMIT, 8'd3);
    write_reg(REG_PROCESS_LIMIT, 8'd2);
    random_phase(350, 35, 2, 3);
    drain();
    // Mostly fresh processes until the process table is full.
    write_reg(REG_USER_LIMIT, 8'd255);
    write_reg(REG_PROCESS_LIMIT, 8'd255);
    random_phase(600, 10, 0, 90);
    drain();
    // Fresh users until the user table is full.
    write_reg(REG_USER_LIMIT, 8'd1);
    random_phase(350, 20, 50, 5);
    drain();
    write_reg(REG_USER_LIMIT, 8'($urandom_range(1, 255)));
    write_reg(REG_PROCESS_LIMIT, 8'($urandom_range(1, 255)));
    random_phase(350, 40, 10, 10);
    drain();

    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/qt_pkg.sv
hw/rtl/qt_ram.sv
hw/rtl/two_level_quota_tracker_top.sv
tb/testbench.sv
